FILE: rtl/core/cbq_pkg.sv
// Shared types of the codebook quantiser.
`timescale 1ns / 1ps
`default_nettype none

package cbq_pkg;

   // Operation carried by each request word.
   typedef enum logic [1:0] {
      MODE_LOAD       = 2'd0,
      MODE_NEAREST    = 2'd1,
      MODE_STOCHASTIC = 2'd2,
      MODE_DECODE     = 2'd3
   } mode_type;

   localparam int unsigned CODE_BITS  = 7;
   localparam int unsigned COUNT_BITS = 8;
   localparam int unsigned FIELD_BITS = 32;

endpackage

`default_nettype wire

FILE: rtl/core/cbq_level_ram.sv
// Level table: one write port and two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module cbq_level_ram #(
   parameter int unsigned DEPTH = 128,
   parameter int unsigned WIDTH = 32,
   parameter int unsigned AW    = 7
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_a,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

FILE: rtl/core/codebook_quantizer.sv
// Top level of the codebook quantiser: sequencer, searches and result register.
//
// The block holds a table of up to MAX_LEVELS sorted Q16.16 levels in a
// two-read-port memory. A load word gives no result and leaves the sequencer
// at rest. A decode word reads its level and passes through the evaluation
// and output states. A nearest word runs a binary search that reads the
// table once per cycle, then one read of the two bracketing levels, one
// compare and the output state; the stochastic mode adds a multiply state,
// its two mirrored searches run side by side on the two read ports and its
// random scaling uses one registered multiplier. The next word is taken once
// the sequencer is back at rest, even while the previous result still waits
// at the output.
`timescale 1ns / 1ps
`default_nettype none

module codebook_quantizer #(
   parameter int unsigned MAX_LEVELS  = 128,
   parameter int unsigned VALUE_BITS  = 32,
   parameter int unsigned RANDOM_BITS = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wr_en,
   input  wire logic [7:0]          csr_wr_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [1:0]          req_mode,
   input  wire logic [6:0]          req_load_index,
   input  wire logic signed [31:0]  req_level_value,
   input  wire logic signed [31:0]  req_sample,
   input  wire logic [15:0]         req_random_fraction,
   input  wire logic signed [7:0]   req_code_in,
   input  wire logic                req_last_in,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [6:0]               rsp_code_out,
   output logic signed [31:0]       rsp_decoded_value,
   output logic                     rsp_unknown_code,
   output logic                     rsp_last_out
);

   localparam int unsigned IW  = $clog2(MAX_LEVELS);
   localparam int unsigned CW  = IW + 1;
   localparam int unsigned VW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
   localparam int unsigned RW  = (RANDOM_BITS < 16) ? RANDOM_BITS : 16;
   localparam int unsigned PW  = RW + VW;
   localparam int unsigned XW  = PW + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_EVAL,
      ST_MULT,
      ST_OUT
   } state_type;

   state_type           state_ff;
   cbq_pkg::mode_type   mode_ff;
   cbq_pkg::mode_type   req_mode_cast;
   logic [7:0]          level_count_ff;
   logic [CW-1:0]       n_eff;
   logic [CW-1:0]       n_ff;
   logic signed [VW-1:0] s_ff;
   logic [RW-1:0]       rnd_ff;
   logic                last_ff;
   logic                unk_ff;
   logic                req_unk;

   logic [IW-1:0]       lo_a_ff, lo_a_in, hi_a_ff, hi_a_in;
   logic [IW-1:0]       lo_b_ff, lo_b_in, hi_b_ff, hi_b_in;
   logic [IW-1:0]       addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;
   logic [CW-1:0]       sum_a, sum_b, next_idx;
   logic                search_done;

   logic                wr_en;
   logic [VW-1:0]       rd_data_a, rd_data_b;
   logic signed [VW-1:0] rd_a_sx, rd_b_sx;
   logic signed [VW:0]  two_s, sum_ab, span, mark;
   logic                near_low;

   logic [PW-1:0]       prod_ff;
   logic signed [VW:0]  mark_ff;
   logic                take_ff;
   logic signed [XW-1:0] scaled;
   logic                go_up;

   logic [6:0]          res_code_ff;
   logic signed [31:0]  res_dec_ff;
   logic                res_unk_ff;
   logic                rsp_valid_ff;
   logic [6:0]          rsp_code_ff;
   logic signed [31:0]  rsp_dec_ff;
   logic                rsp_unk_ff;
   logic                rsp_last_ff;
   logic                out_load;

   assign req_mode_cast = cbq_pkg::mode_type'(req_mode);
   assign req_ready     = (state_ff == ST_IDLE);

   // A count of zero behaves as one and a count above the table as the table.
   assign n_eff = (level_count_ff == 8'd0) ? CW'(1) :
                  (level_count_ff > 8'(MAX_LEVELS)) ? CW'(MAX_LEVELS) :
                  CW'(level_count_ff);

   assign req_unk = req_code_in[7] || ({1'b0, req_code_in[6:0]} >= 8'(n_eff));

   assign wr_en = req_valid && (state_ff == ST_IDLE) &&
                  (req_mode_cast == cbq_pkg::MODE_LOAD) &&
                  ({1'b0, req_load_index} < 8'(MAX_LEVELS));

   cbq_level_ram #(
      .DEPTH (MAX_LEVELS),
      .WIDTH (VW),
      .AW    (IW)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (req_load_index[IW-1:0]),
      .wr_data   (req_level_value[VW-1:0]),
      .rd_addr_a (addr_a_in),
      .rd_addr_b (addr_b_in),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   assign rd_a_sx = rd_data_a;
   assign rd_b_sx = rd_data_b;

   // The read address is the next value of the address register, so the
   // registered read data always belongs to addr_a_ff and addr_b_ff. Loads
   // are only taken at rest, which keeps writes clear of any search.
   always_comb begin
      lo_a_in     = lo_a_ff;
      hi_a_in     = hi_a_ff;
      lo_b_in     = lo_b_ff;
      hi_b_in     = hi_b_ff;
      addr_a_in   = addr_a_ff;
      addr_b_in   = addr_b_ff;
      sum_a       = '0;
      sum_b       = '0;
      next_idx    = '0;
      search_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_mode_cast != cbq_pkg::MODE_LOAD)) begin
               lo_a_in   = '0;
               hi_a_in   = IW'(n_eff - CW'(1));
               lo_b_in   = '0;
               hi_b_in   = (req_mode_cast == cbq_pkg::MODE_STOCHASTIC) ?
                           IW'(n_eff - CW'(1)) : '0;
               addr_a_in = (req_mode_cast == cbq_pkg::MODE_DECODE) ?
                           req_code_in[IW-1:0] : n_eff[IW:1];
               addr_b_in = n_eff[IW:1];
            end
         end
         ST_SEARCH: begin
            // Lower search: greatest level not above the sample.
            if (hi_a_ff > lo_a_ff) begin
               if (s_ff > rd_a_sx) begin
                  lo_a_in = addr_a_ff;
               end else if (s_ff < rd_a_sx) begin
                  hi_a_in = addr_a_ff - IW'(1);
               end else begin
                  lo_a_in = addr_a_ff;
                  hi_a_in = addr_a_ff;
               end
            end
            // Upper search: least level not below the sample.
            if (hi_b_ff > lo_b_ff) begin
               if (s_ff > rd_b_sx) begin
                  lo_b_in = addr_b_ff + IW'(1);
               end else if (s_ff < rd_b_sx) begin
                  hi_b_in = addr_b_ff;
               end else begin
                  lo_b_in = addr_b_ff;
                  hi_b_in = addr_b_ff;
               end
            end
            sum_a    = {1'b0, hi_a_in} + {1'b0, lo_a_in} + CW'(1);
            sum_b    = {1'b0, hi_b_in} + {1'b0, lo_b_in};
            next_idx = {1'b0, lo_a_in} + CW'(1);
            if (!(hi_a_in > lo_a_in) && !(hi_b_in > lo_b_in)) begin
               search_done = 1'b1;
               addr_a_in   = lo_a_in;
               if (mode_ff == cbq_pkg::MODE_NEAREST) begin
                  addr_b_in = (next_idx < n_ff) ? next_idx[IW-1:0] :
                              IW'(n_ff - CW'(1));
               end else begin
                  addr_b_in = hi_b_in;
               end
            end else begin
               addr_a_in = sum_a[IW:1];
               addr_b_in = sum_b[IW:1];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      lo_a_ff   <= lo_a_in;
      hi_a_ff   <= hi_a_in;
      lo_b_ff   <= lo_b_in;
      hi_b_ff   <= hi_b_in;
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
   end

   assign two_s    = {s_ff, 1'b0};
   assign sum_ab   = (VW+1)'(rd_a_sx) + (VW+1)'(rd_b_sx);
   assign near_low = (two_s < sum_ab);
   assign span     = (VW+1)'(rd_b_sx) - (VW+1)'(rd_a_sx);
   assign mark     = (VW+1)'(s_ff) - (VW+1)'(rd_a_sx);
   assign scaled   = {1'b0, PW'(prod_ff >> RANDOM_BITS)};
   assign go_up    = take_ff && (scaled <= XW'(mark_ff));

   // The output register takes a new word when it is empty or being emptied.
   assign out_load = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         level_count_ff <= 8'd1;
      end else begin
         if (csr_wr_en) begin
            level_count_ff <= csr_wr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  mode_ff <= req_mode_cast;
                  s_ff    <= req_sample[VW-1:0];
                  rnd_ff  <= req_random_fraction[RW-1:0];
                  last_ff <= req_last_in;
                  n_ff    <= n_eff;
                  unk_ff  <= req_unk;
                  case (req_mode_cast)
                     cbq_pkg::MODE_LOAD:   state_ff <= ST_IDLE;
                     cbq_pkg::MODE_DECODE: state_ff <= ST_EVAL;
                     default:              state_ff <= ST_SEARCH;
                  endcase
               end
            end
            ST_SEARCH: begin
               if (search_done) begin
                  state_ff <= ST_EVAL;
               end
            end
            ST_EVAL: begin
               case (mode_ff)
                  cbq_pkg::MODE_NEAREST: begin
                     res_dec_ff  <= '0;
                     res_unk_ff  <= 1'b0;
                     res_code_ff <= near_low ? 7'(addr_a_ff) : 7'(addr_b_ff);
                     state_ff    <= ST_OUT;
                  end
                  cbq_pkg::MODE_STOCHASTIC: begin
                     res_dec_ff <= '0;
                     res_unk_ff <= 1'b0;
                     // An unsorted table can give a span that is not positive.
                     prod_ff  <= PW'(rnd_ff) * PW'(span[VW-1:0]);
                     mark_ff  <= mark;
                     take_ff  <= (addr_a_ff != addr_b_ff) && !span[VW] &&
                                 (span != '0);
                     state_ff <= ST_MULT;
                  end
                  cbq_pkg::MODE_DECODE: begin
                     res_code_ff <= '0;
                     res_dec_ff  <= unk_ff ? '0 : 32'(rd_a_sx);
                     res_unk_ff  <= unk_ff;
                     state_ff    <= ST_OUT;
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_MULT: begin
               res_code_ff <= go_up ? 7'(addr_b_ff) : 7'(addr_a_ff);
               state_ff    <= ST_OUT;
            end
            ST_OUT: begin
               if (out_load) begin
                  rsp_code_ff  <= res_code_ff;
                  rsp_dec_ff   <= res_dec_ff;
                  rsp_unk_ff   <= res_unk_ff;
                  rsp_last_ff  <= last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_code_out      = rsp_code_ff;
   assign rsp_decoded_value = rsp_dec_ff;
   assign rsp_unknown_code  = rsp_unk_ff;
   assign rsp_last_out      = rsp_last_ff;

endmodule

`default_nettype wire

FILE: bench/codebook_quantizer_test.sv
// Self-checking testbench of the codebook quantiser: directed words, then random phases.
`timescale 1ns / 1ps

localparam int TABLE_DEPTH  = 128;
localparam int SETTLE_WAIT  = 20;
localparam int HOLD_CYCLES  = 400;
localparam int STALL_LIMIT  = 3000;
localparam int TARGET_WORDS = 1200;

typedef struct packed {
   cbq_pkg::mode_type  mode;
   logic [6:0]         load_index;
   logic signed [31:0] level_value;
   logic signed [31:0] sample;
   logic [15:0]        random_fraction;
   logic signed [7:0]  code_in;
   logic               last_in;
} request_type;

typedef struct packed {
   logic [6:0]         code;
   logic signed [31:0] value;
   logic               unknown;
   logic               last_flag;
} result_type;

class result_board;
   logic signed [31:0] levels [TABLE_DEPTH];
   logic [7:0]         count_reg;
   result_type         expected_q [$];
   int                 errors;

   function new();
      for (int i = 0; i < TABLE_DEPTH; i++) levels[i] = '0;
      count_reg = 8'd1;
      errors = 0;
   endfunction

   function void set_count(logic [7:0] value);
      count_reg = value;
   endfunction

   function int pending();
      return expected_q.size();
   endfunction

   // Out-of-range counts are clamped to the table.
   function int live_count();
      int n;
      n = int'(count_reg);
      if (n < 1) n = 1;
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return n;
   endfunction

   // Greatest level not above the sample, or 0 when none is.
   function int floor_index(longint s, int n);
      int     hi, lo, mid;
      longint v;
      hi = n - 1;
      lo = 0;
      mid = n >> 1;
      while (hi > lo) begin
         v = levels[mid];
         if (s > v) lo = mid;
         else if (s < v) hi = mid - 1;
         else return mid;
         mid = (hi + lo + 1) >> 1;
      end
      return lo;
   endfunction

   // Least level not below the sample, or the top index when none is.
   function int ceil_index(longint s, int n);
      int     hi, lo, mid;
      longint v;
      hi = n - 1;
      lo = 0;
      mid = n >> 1;
      while (hi > lo) begin
         v = levels[mid];
         if (s > v) lo = mid + 1;
         else if (s < v) hi = mid;
         else return mid;
         mid = (hi + lo) >> 1;
      end
      return hi;
   endfunction

   function void note_request(request_type r);
      int         n, lo, up, code;
      longint     s, a, b, span, mark, scaled;
      result_type e;
      n = live_count();
      s = longint'($signed(r.sample));
      e = '0;
      e.last_flag = r.last_in;
      case (r.mode)
         cbq_pkg::MODE_LOAD: begin
            levels[r.load_index] = r.level_value;
            return;
         end
         cbq_pkg::MODE_NEAREST: begin
            lo = floor_index(s, n);
            a = levels[lo];
            b = (lo + 1 < n) ? levels[lo + 1] : levels[n - 1];
            // Ties go to the upper level.
            if (2 * s < a + b) e.code = 7'(lo);
            else e.code = 7'((lo + 1 >= n) ? n - 1 : lo + 1);
         end
         cbq_pkg::MODE_STOCHASTIC: begin
            lo = floor_index(s, n);
            up = ceil_index(s, n);
            e.code = 7'(lo);
            if (lo != up) begin
               span = longint'(levels[up]) - longint'(levels[lo]);
               mark = s - longint'(levels[lo]);
               if (span > 0) begin
                  scaled = (longint'(r.random_fraction) * span) >>> 16;
                  if (scaled <= mark) e.code = 7'(up);
               end
            end
         end
         default: begin
            code = int'($signed(r.code_in));
            if (code < 0 || code >= n) e.unknown = 1'b1;
            else e.value = levels[code];
         end
      endcase
      expected_q.push_back(e);
   endfunction

   function void check_result(result_type got);
      result_type e;
      if (expected_q.size() == 0) begin
         $display("%0t: unexpected word: code %0d value %h unknown %0d last %0d",
                  $time, got.code, got.value, got.unknown, got.last_flag);
         errors++;
         return;
      end
      e = expected_q.pop_front();
      if (got.code !== e.code) begin
         $display("%0t: code_out expected %0d actual %0d", $time, e.code, got.code);
         errors++;
      end
      if (got.value !== e.value) begin
         $display("%0t: decoded_value expected %h actual %h", $time, e.value, got.value);
         errors++;
      end
      if (got.unknown !== e.unknown) begin
         $display("%0t: unknown_code expected %0d actual %0d", $time, e.unknown,
                  got.unknown);
         errors++;
      end
      if (got.last_flag !== e.last_flag) begin
         $display("%0t: last_out expected %0d actual %0d", $time, e.last_flag,
                  got.last_flag);
         errors++;
      end
   endfunction
endclass

module codebook_quantizer_test;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wr_en = 1'b0;
   logic [7:0]         csr_wr_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_mode = '0;
   logic [6:0]         req_load_index = '0;
   logic signed [31:0] req_level_value = '0;
   logic signed [31:0] req_sample = '0;
   logic [15:0]        req_random_fraction = '0;
   logic signed [7:0]  req_code_in = '0;
   logic               req_last_in = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [6:0]         rsp_code_out;
   logic signed [31:0] rsp_decoded_value;
   logic               rsp_unknown_code;
   logic               rsp_last_out;

   result_board sb;
   int          words_sent = 0;
   int          rsp_hold = 0;
   int          idle_cycles = 0;
   bit          tx_quiet = 1'b0;
   bit          rx_quiet = 1'b0;
   int          phase_levels [$];
   int          level_base;

   codebook_quantizer i_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_load_index      (req_load_index),
      .req_level_value     (req_level_value),
      .req_sample          (req_sample),
      .req_random_fraction (req_random_fraction),
      .req_code_in         (req_code_in),
      .req_last_in         (req_last_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_code_out        (rsp_code_out),
      .rsp_decoded_value   (rsp_decoded_value),
      .rsp_unknown_code    (rsp_unknown_code),
      .rsp_last_out        (rsp_last_out)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("codebook_quantizer verification failed");
         $finish;
      end
   end

   // Every field but the mode is random; the caller may override the ones the mode uses.
   function automatic request_type fresh_request(cbq_pkg::mode_type m);
      request_type r;
      r.mode = m;
      r.load_index = 7'($urandom);
      r.level_value = $urandom;
      r.sample = $urandom;
      r.random_fraction = 16'($urandom);
      r.code_in = 8'($urandom);
      r.last_in = 1'($urandom);
      return r;
   endfunction

   task automatic send(request_type r);
      int gap;
      gap = tx_quiet ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_mode <= r.mode;
      req_load_index <= r.load_index;
      req_level_value <= r.level_value;
      req_sample <= r.sample;
      req_random_fraction <= r.random_fraction;
      req_code_in <= r.code_in;
      req_last_in <= r.last_in;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_request(r);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic load_level(int index, int value);
      request_type r;
      r = fresh_request(cbq_pkg::MODE_LOAD);
      r.load_index = 7'(index);
      r.level_value = value;
      send(r);
   endtask

   task automatic issue(cbq_pkg::mode_type m, int sample, int fraction, int code);
      request_type r;
      r = fresh_request(m);
      r.sample = sample;
      r.random_fraction = 16'(fraction);
      r.code_in = 8'(code);
      send(r);
   endtask

   // Holds the input off until every result is out and the block has settled.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
   endtask

   task automatic write_count(logic [7:0] value);
      drain_block();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.set_count(value);
   endtask

   function automatic int gen_level(int style);
      case (style)
         0: return $urandom;
         1: return level_base + $urandom_range(0, 255);
         2: return $urandom_range(0, 1 << 21) - (1 << 20);
         default: return ($urandom_range(0, 63) - 32) <<< 16;
      endcase
   endfunction

   // Samples go onto levels, midpoints and near levels, or are random or extreme.
   function automatic int pick_sample(int n);
      int     k, a, b;
      longint mid;
      k = $urandom_range(0, n - 1);
      a = phase_levels[k];
      b = (k + 1 < n) ? phase_levels[k + 1] : a;
      case ($urandom_range(0, 7))
         0: return a;
         1, 2: return a + $urandom_range(0, 16) - 8;
         3: begin
            mid = (longint'(a) + longint'(b)) >>> 1;
            return int'(mid);
         end
         4: return $urandom;
         5: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return a + $urandom_range(0, 1 << 16);
      endcase
   endfunction

   task automatic random_word(int n);
      request_type r;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         r = fresh_request(cbq_pkg::MODE_LOAD);
         if ($urandom_range(0, 1)) r.level_value = pick_sample(n);
         if (int'(r.load_index) < n) phase_levels[r.load_index] = r.level_value;
      end else if (pick < 72) begin
         if (pick < 38) r = fresh_request(cbq_pkg::MODE_NEAREST);
         else r = fresh_request(cbq_pkg::MODE_STOCHASTIC);
         r.sample = pick_sample(n);
         if ($urandom_range(0, 9) == 0) r.random_fraction = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      end else begin
         r = fresh_request(cbq_pkg::MODE_DECODE);
         if ($urandom_range(0, 4) != 0) r.code_in = 8'($urandom_range(0, n - 1));
      end
      send(r);
   endtask

   task automatic run_phase(logic [7:0] cfg, bit hold);
      int n, words, style, k;
      bit sorted_table, descending;
      n = (cfg == 0) ? 1 : (int'(cfg) > TABLE_DEPTH ? TABLE_DEPTH : int'(cfg));
      write_count(cfg);
      style = $urandom_range(0, 3);
      level_base = $urandom;
      sorted_table = ($urandom_range(0, 99) < 85);
      descending = $urandom_range(0, 1);
      phase_levels.delete();
      for (k = 0; k < n; k++) phase_levels.push_back(gen_level(style));
      if (sorted_table) phase_levels.sort();
      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      if (hold) rsp_hold = HOLD_CYCLES;
      for (k = 0; k < n; k++) begin
         if (descending) load_level(n - 1 - k, phase_levels[n - 1 - k]);
         else load_level(k, phase_levels[k]);
      end
      // Entries above the live count are stored but never searched.
      if (n < TABLE_DEPTH && $urandom_range(0, 3) == 0)
         load_level($urandom_range(n, TABLE_DEPTH - 1), $urandom);
      words = $urandom_range(20, 70);
      for (k = 0; k < words; k++) random_word(n);
   endtask

   // Result side: random back-pressure, with one long hold-off when asked for.
   initial begin
      int         gap;
      result_type got;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (rsp_hold > 0) begin
            gap = rsp_hold;
            rsp_hold = 0;
         end else begin
            gap = rx_quiet ? 0 : $urandom_range(0, 14);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.code = rsp_code_out;
         got.value = rsp_decoded_value;
         got.unknown = rsp_unknown_code;
         got.last_flag = rsp_last_out;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      int         phase_no;
      logic [7:0] cfg;
      sb = new();
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed words on a four-level table spanning the full range.
      write_count(8'd4);
      load_level(0, 32'h8000_0000);
      load_level(1, -65536);
      load_level(2, 65536);
      load_level(3, 32'h7FFF_FFFF);
      load_level(127, 32'h0001_2345);
      issue(cbq_pkg::MODE_NEAREST, 0, 0, 0);
      issue(cbq_pkg::MODE_NEAREST, 32'h7FFF_FFFF, 0, 0);
      issue(cbq_pkg::MODE_NEAREST, 32'h8000_0000, 0, 0);
      issue(cbq_pkg::MODE_NEAREST, -32768, 0, 0);
      issue(cbq_pkg::MODE_STOCHASTIC, 0, 0, 0);
      issue(cbq_pkg::MODE_STOCHASTIC, -65535, 16'hFFFF, 0);
      issue(cbq_pkg::MODE_STOCHASTIC, 32768, 32768, 0);
      issue(cbq_pkg::MODE_STOCHASTIC, 65536, 12345, 0);
      issue(cbq_pkg::MODE_STOCHASTIC, 32'h8000_0000, 16'hFFFF, 0);
      issue(cbq_pkg::MODE_DECODE, 0, 0, 0);
      issue(cbq_pkg::MODE_DECODE, 0, 0, 3);
      issue(cbq_pkg::MODE_DECODE, 0, 0, 4);
      issue(cbq_pkg::MODE_DECODE, 0, 0, -1);
      issue(cbq_pkg::MODE_DECODE, 0, 0, -128);
      issue(cbq_pkg::MODE_DECODE, 0, 0, 127);
      // An out-of-order entry makes the table unsorted.
      load_level(2, -100000);
      issue(cbq_pkg::MODE_STOCHASTIC, -70000, 16'hFFFF, 0);
      issue(cbq_pkg::MODE_NEAREST, -70000, 0, 0);

      phase_no = 0;
      while (words_sent < TARGET_WORDS) begin
         case (phase_no)
            0: cfg = 8'd0;
            1: cfg = 8'd255;
            2: cfg = 8'd128;
            3: cfg = 8'd1;
            4: cfg = 8'd2;
            default: begin
               case ($urandom_range(0, 19))
                  0: cfg = 8'd128;
                  1: cfg = 8'($urandom_range(129, 255));
                  2: cfg = 8'd0;
                  3, 4: cfg = 8'($urandom_range(17, 64));
                  default: cfg = 8'($urandom_range(1, 16));
               endcase
            end
         endcase
         run_phase(cfg, phase_no == 1 || $urandom_range(0, 19) == 0);
         phase_no++;
      end

      drain_block();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("codebook_quantizer verification clean");
      end else begin
         $display("codebook_quantizer verification failed");
      end
      $finish;
   end

endmodule
